[rtl/tba_pkg.sv]
// ----------------------------------------------------------------------------
// tba_pkg
// Shared types and constants of the tick-to-bar aggregator.
// ----------------------------------------------------------------------------
package tba_pkg;

  localparam int SecW   = 17;
  localparam int PriceW = 32;
  localparam int MergeW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 17;

  localparam logic [CfgIdxW-1:0] CfgMorningOpen    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMorningClose   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAfternoonOpen  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAfternoonClose = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBarSeconds     = 3'd4;

  localparam logic [1:0] StRejected = 2'd0;
  localparam logic [1:0] StAdded    = 2'd1;
  localparam logic [1:0] StClosed   = 2'd2;
  localparam logic [1:0] StMerged   = 2'd3;

  typedef struct packed {
    logic [SecW-1:0]   start;
    logic [PriceW-1:0] open;
    logic [PriceW-1:0] high;
    logic [PriceW-1:0] low;
    logic [PriceW-1:0] close;
    logic [MergeW-1:0] merged;
  } bar_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              accepted;
    logic [SecW-1:0]   secs;
    logic [SecW-1:0]   start;
    logic [PriceW-1:0] price;
  } cls_t;

  typedef struct packed {
    logic [1:0]        status;
    bar_t              bar;
    logic [PriceW-1:0] average;
  } res_t;

endpackage

[rtl/tba_if.sv]
// ----------------------------------------------------------------------------
// tba_if
// Valid/ready channel interfaces for ticks, results and configuration.
// ----------------------------------------------------------------------------
interface tba_tick_if;
  logic        valid;
  logic        ready;
  logic [16:0] tick_seconds;
  logic [31:0] tick_price;
  modport source (output valid, tick_seconds, tick_price, input ready);
  modport sink (input valid, tick_seconds, tick_price, output ready);
endinterface

interface tba_bar_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] bar_start;
  logic [31:0] bar_open;
  logic [31:0] bar_high;
  logic [31:0] bar_low;
  logic [31:0] bar_close;
  logic [31:0] bar_average;
  logic [15:0] bars_merged;
  modport source (output valid, status, bar_start, bar_open, bar_high, bar_low,
                  bar_close, bar_average, bars_merged, input ready);
  modport sink (input valid, status, bar_start, bar_open, bar_high, bar_low,
                bar_close, bar_average, bars_merged, output ready);
endinterface

interface tba_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tick_to_bar_aggregator_with_merge_unit.sv]
// ----------------------------------------------------------------------------
// tick_to_bar_aggregator_with_merge_unit
// OHLC bar builder with inclusion merge and moving average of closes.
// ----------------------------------------------------------------------------
// One result per tick. The front splits each tick into minute and second of
// minute by reciprocal multiply, then takes the remainder of the second by the
// bar length in a restoring division, and hands the item to the back. A tick
// that closes a bar also waits on the history RAM reads (one port,
// registered, up to four older bars read for the average of closes), one
// extra pass when a merge happens, and the bit-serial divider for the close
// average. The front accepts the next tick while the back works; a result
// waiting on the output stalls the back.
module tick_to_bar_aggregator_with_merge_unit #(
  parameter int HISTORY_DEPTH = 8,
  parameter int AVERAGE_SPAN  = 5
) (
  input  logic       clk,
  input  logic       rst,
  tba_tick_if.sink   tick,
  tba_cfg_if.sink    cfg,
  tba_bar_if.source  bar
);
  import tba_pkg::*;

  logic       q_valid, q_ready;
  cls_t       q_item;
  logic [5:0] bar_len;

  tba_front u_front (
    .clk(clk), .rst(rst), .tick(tick), .cfg(cfg), .bar_len(bar_len),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  tba_back #(.HistoryDepth(HISTORY_DEPTH), .AverageSpan(AVERAGE_SPAN)) u_back (
    .clk(clk), .rst(rst), .bar_len(bar_len), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .bar(bar)
  );
endmodule

[rtl/tba_front.sv]
// ----------------------------------------------------------------------------
// tba_front
// Session test and bar start computation for each incoming tick.
// ----------------------------------------------------------------------------
module tba_front (
  input  logic                        clk,
  input  logic                        rst,
  tba_tick_if.sink                    tick,
  tba_cfg_if.sink                     cfg,
  output logic [5:0]                  bar_len,
  output logic                        q_valid,
  input  logic                        q_ready,
  output tba_pkg::cls_t               q_item
);
  import tba_pkg::*;

  // 2^23 / 60 rounded up: exact minute count for every second of the day
  localparam logic [17:0] MinRecip = 18'd139811;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MIN  = 4'b0010,
    F_DIV  = 4'b0100,
    F_HOLD = 4'b1000
  } fstate_t;

  fstate_t           fstate;
  logic [SecW-1:0]   morning_open, morning_close, afternoon_open, afternoon_close;
  logic [5:0]        bar_seconds;
  logic              in_sess;
  logic [34:0]       prod;
  logic [10:0]       minute;
  logic [SecW-1:0]   min_base_c;
  logic [SecW-1:0]   secs_off;
  logic [SecW-1:0]   min_base;
  logic              w_acc;
  logic [SecW-1:0]   w_secs;
  logic [PriceW-1:0] w_price;
  logic [5:0]        ss;
  logic [5:0]        dvd;
  logic [5:0]        rem;
  logic [6:0]        shifted;
  logic [7:0]        trial;
  logic [2:0]        dcnt;
  logic [5:0]        floor_ss;
  logic              load;

  assign cfg.ready  = 1'b1;
  assign tick.ready = (fstate == F_IDLE);
  assign bar_len    = (bar_seconds == 6'd0) ? 6'd1 : bar_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      morning_open    <= 17'd34200;
      morning_close   <= 17'd41400;
      afternoon_open  <= 17'd46800;
      afternoon_close <= 17'd55800;
      bar_seconds     <= 6'd15;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgMorningOpen:    morning_open    <= cfg.data;
        CfgMorningClose:   morning_close   <= cfg.data;
        CfgAfternoonOpen:  afternoon_open  <= cfg.data;
        CfgAfternoonClose: afternoon_close <= cfg.data;
        CfgBarSeconds:     bar_seconds     <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_sess = (tick.tick_seconds >= morning_open && tick.tick_seconds <= morning_close) ||
              (tick.tick_seconds >= afternoon_open && tick.tick_seconds <= afternoon_close);
    prod       = {18'd0, tick.tick_seconds} * {17'd0, MinRecip};
    min_base_c = {minute, 6'd0} - {4'd0, minute, 2'd0};
    secs_off   = w_secs - min_base_c;
    shifted    = {rem, dvd[5]};
    trial      = {1'b0, shifted} - {2'b0, bar_len};
    floor_ss   = ss - rem;
  end

  assign load = (fstate == F_HOLD) && (!q_valid || q_ready);

  // tick capture, minute split, then second of minute mod bar length: restoring division, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      unique case (fstate)
        F_IDLE: if (tick.valid) begin
          w_acc   <= in_sess;
          w_secs  <= tick.tick_seconds;
          w_price <= tick.tick_price;
          minute  <= prod[33:23];
          fstate  <= F_MIN;
        end
        F_MIN: begin
          min_base <= min_base_c;
          ss       <= secs_off[5:0];
          dvd      <= secs_off[5:0];
          rem      <= '0;
          dcnt     <= '0;
          fstate   <= F_DIV;
        end
        F_DIV: begin
          rem    <= trial[7] ? shifted[5:0] : trial[5:0];
          dvd    <= {dvd[4:0], 1'b0};
          dcnt   <= dcnt + 1'b1;
          if (dcnt == 3'd5) fstate <= F_HOLD;
        end
        F_HOLD: if (load) fstate <= F_IDLE;
        default: fstate <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (load) q_valid <= 1'b1;
    else if (q_ready) q_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_item.accepted <= w_acc;
      q_item.secs     <= w_secs;
      q_item.start    <= min_base + {11'd0, floor_ss};
      q_item.price    <= w_price;
    end
  end
endmodule

[rtl/tba_ram.sv]
// ----------------------------------------------------------------------------
// tba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tba_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/tba_back.sv]
// ----------------------------------------------------------------------------
// tba_back
// Bar state, circular history, merge and averaging sequencer.
// ----------------------------------------------------------------------------
module tba_back #(
  parameter int HistoryDepth = 8,
  parameter int AverageSpan  = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [5:0]    bar_len,
  input  logic          q_valid,
  output logic          q_ready,
  input  tba_pkg::cls_t q_item,
  tba_bar_if.source     bar
);
  import tba_pkg::*;

  localparam int AW = $clog2(HistoryDepth);
  localparam int CW = $clog2(HistoryDepth + 1);
  localparam int NW = $clog2(AverageSpan + 1);
  localparam int SW = PriceW + NW;
  localparam int BW = $bits(bar_t);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD1   = 10'b0000000010,
    S_RD1W  = 10'b0000000100,
    S_RD2   = 10'b0000001000,
    S_RD2W  = 10'b0000010000,
    S_MERGE = 10'b0000100000,
    S_SUM   = 10'b0001000000,
    S_SUMW  = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic          active;
  bar_t          cur;
  logic [AW-1:0] head;     // slot of newest history bar
  logic [CW-1:0] count;
  bar_t          b0, b1;   // newest and second history bars
  logic [PriceW-1:0] h2;
  logic          merged;
  cls_t          it;
  logic [SW-1:0] sum;
  logic [NW-1:0] n;
  logic [NW-1:0] idx;
  logic [SW-1:0] rem;
  logic [PriceW-1:0] quo;
  logic [5:0]    dstep;
  res_t          res;

  logic          we;
  logic [AW-1:0] addr;
  bar_t          wdata, rdata;
  logic [BW-1:0] rraw;

  tba_ram #(.Width(BW), .Depth(HistoryDepth)) u_hist (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rraw)
  );
  assign rdata = bar_t'(rraw);

  function automatic logic [AW-1:0] slot(logic [AW-1:0] h, logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(off);
    if (s >= (AW+1)'(HistoryDepth)) s = s - (AW+1)'(HistoryDepth);
    return s[AW-1:0];
  endfunction

  logic closes;
  logic [SecW:0] bar_end;
  assign bar_end = {1'b0, cur.start} + {12'd0, bar_len};
  assign closes  = active && ({1'b0, it.secs} >= bar_end);

  logic [PriceW-1:0] mh, ml;
  logic rising, do_merge;
  logic [MergeW:0] msum;
  always_comb begin
    do_merge = (count >= CW'(2)) &&
               !((b0.high > b1.high && b0.low > b1.low) ||
                 (b0.high < b1.high && b0.low < b1.low));
    rising = (count < CW'(3)) || (b1.high > h2);
    mh = rising ? ((b0.high > b1.high) ? b0.high : b1.high)
                : ((b0.high < b1.high) ? b0.high : b1.high);
    ml = rising ? ((b0.low > b1.low) ? b0.low : b1.low)
                : ((b0.low < b1.low) ? b0.low : b1.low);
    msum = {1'b0, b0.merged} + {1'b0, b1.merged};
  end

  logic [SW:0] trial;
  assign trial = {rem[SW-2:0], sum[SW-1]} - {{(SW+1-NW){1'b0}}, n};

  assign q_ready = (state == S_IDLE) && !bar.valid;

  always_comb begin
    we = 1'b0; addr = head; wdata = b0;
    unique case (state)
      S_RD1: addr = slot(head, CW'(1));
      S_RD2: addr = slot(head, CW'(2));
      S_SUM: addr = slot(head, CW'(idx));
      S_MERGE: begin we = 1'b1; addr = head; wdata = b0; end
      default: ;
    endcase
    if (state == S_IDLE && q_valid && q_ready && q_item.accepted &&
        active && ({1'b0, q_item.secs} >= {1'b0, cur.start} + {12'd0, bar_len})) begin
      we = 1'b1; addr = (head == '0) ? AW'(HistoryDepth - 1) : head - 1'b1; wdata = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; active <= 1'b0; count <= '0; head <= '0;
      bar.valid <= 1'b0;
      cur <= '0;
    end else begin
      if (bar.valid && bar.ready) bar.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_ready) begin
          it <= q_item;
          merged <= 1'b0;
          if (!q_item.accepted) begin
            res <= '0; bar.valid <= 1'b1;
          end else if (active &&
                      ({1'b0, q_item.secs} >= {1'b0, cur.start} + {12'd0, bar_len})) begin
            head <= (head == '0) ? AW'(HistoryDepth - 1) : head - 1'b1;
            if (count < CW'(HistoryDepth)) count <= count + 1'b1;
            b0 <= cur;
            state <= S_RD1;
          end else begin
            state <= S_OUT;
          end
        end
        S_RD1: state <= S_RD1W;
        S_RD1W: begin b1 <= rdata; state <= S_RD2; end
        S_RD2: state <= S_RD2W;
        S_RD2W: begin h2 <= rdata.high; state <= S_MERGE; end
        S_MERGE: begin
          // b0 written back at head this cycle; at most one merge per close,
          // the merged bar is written on the second pass
          if (do_merge && !merged) begin
            b0.start  <= b1.start;
            b0.high   <= mh;
            b0.low    <= ml;
            b0.open   <= (b0.open > b0.close) ? mh : ml;
            b0.close  <= (b0.open > b0.close) ? ml : mh;
            b0.merged <= msum[MergeW] ? '1 : msum[MergeW-1:0];
            head      <= slot(head, CW'(1));
            count     <= count - 1'b1;
            merged    <= 1'b1;
            state     <= S_MERGE;
          end else begin
            sum <= SW'(b0.close); n <= NW'(1); idx <= NW'(1);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (CW'(idx) >= count || idx >= NW'(AverageSpan)) begin
            rem <= '0; quo <= '0; dstep <= '0; state <= S_DIV;
          end else state <= S_SUMW;
        end
        S_SUMW: begin
          sum <= sum + SW'(rdata.close); n <= n + 1'b1; idx <= idx + 1'b1;
          state <= S_SUM;
        end
        S_DIV: begin
          // restoring division, one bit a cycle
          if (!trial[SW]) rem <= trial[SW-1:0];
          else rem <= {rem[SW-2:0], sum[SW-1]};
          sum <= {sum[SW-2:0], 1'b0};
          if (dstep >= 6'(SW - PriceW)) quo <= {quo[PriceW-2:0], !trial[SW]};
          dstep <= dstep + 1'b1;
          if (dstep == 6'(SW - 1)) state <= S_OUT;
        end
        S_OUT: begin
          begin : upd
            bar_t nc;
            nc = cur;
            if (!active || closes) begin
              nc.start = it.start; nc.open = it.price; nc.high = it.price;
              nc.low = it.price; nc.merged = MergeW'(1);
            end
            if (it.price > nc.high) nc.high = it.price;
            if (it.price < nc.low) nc.low = it.price;
            nc.close = it.price;
            cur <= nc;
            active <= 1'b1;
            if (closes) begin
              res.status <= merged ? StMerged : StClosed;
              res.bar <= b0;
              res.average <= quo;
            end else begin
              res.status <= StAdded; res.bar <= nc; res.average <= '0;
            end
          end
          bar.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign bar.status      = res.status;
  assign bar.bar_start   = res.bar.start;
  assign bar.bar_open    = res.bar.open;
  assign bar.bar_high    = res.bar.high;
  assign bar.bar_low     = res.bar.low;
  assign bar.bar_close   = res.bar.close;
  assign bar.bar_average = res.average;
  assign bar.bars_merged = res.bar.merged;
endmodule
